// File: sv/ppc_pkg.sv
// Shared types, constants and the step program of the point projection colorizer.
// Used by every module of the block; depends on nothing.
package ppc_pkg;

  // Field and arithmetic widths.
  localparam int COORD_BITS   = 24;
  localparam int FOCAL_LENGTH = 1000;
  localparam int TRIG_FRAC    = 14;
  localparam int TRIG_ONE     = 16384;
  localparam int TRIG_BITS    = 16;
  localparam int LEVEL_MAX    = 255;
  localparam int LEVEL_BITS   = 8;
  localparam int PIX_BITS     = 12;
  localparam int SIZE_BITS    = 13;
  localparam int SIZE_MAX     = 4096;
  localparam int OFF_BITS     = 24;
  localparam int OPA_W        = 18;
  localparam int CAM_W        = COORD_BITS + 18;
  localparam int DEPTH_W      = (CAM_W > OFF_BITS + 16) ? CAM_W + 1 : OFF_BITS + 17;
  localparam int MB_W         = DEPTH_W;
  localparam int NUM_W        = DEPTH_W + OPA_W;
  localparam int QUO_W        = PIX_BITS + 1;
  localparam int CNT_W        = $clog2(QUO_W);
  localparam int STEP_W       = 5;

  // Port widths.
  localparam int IN_DATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 2 * PIX_BITS + 3 * LEVEL_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Reset values of the configuration registers.
  localparam int HEIGHT_RST = 1080;
  localparam int WIDTH_RST  = 1080;
  localparam int OFF_RST    = 50000;

  // Input command codes.
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT, REG_WIDTH, REG_OFFSET, REG_COS_P, REG_SIN_P, REG_COS_A, REG_SIN_A
  } cfg_reg_t;

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_ACC, S_DIV, S_OUT} state_t;

  typedef enum logic [1:0] {K_MAC, K_DIV, K_END} step_kind_t;

  typedef enum logic [3:0] {
    A_COS_P, A_SIN_P, A_COS_A, A_SIN_A, A_TRIG_ONE, A_FOCAL, A_COL_C, A_ROW_C, A_LEVEL
  } opa_sel_t;

  typedef enum logic [3:0] {
    B_WX, B_WY, B_WZ, B_TMP, B_OFF, B_CAM0, B_CAM1, B_DEPTH, B_ABS_X, B_Z_DIFF
  } opb_sel_t;

  typedef enum logic [2:0] {M_TMP, M_LOAD, M_ADD, M_ADD_SH, M_FLOOR_ADD} acc_mode_t;

  typedef enum logic [1:0] {CAP_NONE, CAP_CAM0, CAP_CAM1, CAP_DEPTH} cap_sel_t;

  typedef enum logic [1:0] {D_COL, D_ROW, D_BLUE, D_GREEN} div_dest_t;

  typedef struct packed {
    step_kind_t kind;
    opa_sel_t   a;
    opb_sel_t   b;
    acc_mode_t  mode;
    logic       neg;
    cap_sel_t   cap;
    div_dest_t  dest;
  } step_t;

  typedef struct packed {
    logic      mul_en;
    logic      acc_en;
    acc_mode_t mode;
    logic      neg;
  } mac_ctrl_t;

  function automatic step_t mac_op(input opa_sel_t a, input opb_sel_t b,
                                   input acc_mode_t mode, input logic neg,
                                   input cap_sel_t cap);
    step_t st;
    st = '0;
    st.kind = K_MAC;
    st.a    = a;
    st.b    = b;
    st.mode = mode;
    st.neg  = neg;
    st.cap  = cap;
    return st;
  endfunction

  function automatic step_t div_op(input div_dest_t dest);
    step_t st;
    st = '0;
    st.kind = K_DIV;
    st.dest = dest;
    return st;
  endfunction

  // Step program of one projected item. The rotation rows of cam0 and depth are
  // built from nested products so that every multiply stays narrow.
  function automatic step_t prog_step(input logic [STEP_W-1:0] s);
    step_t st;
    st = '0;
    st.kind = K_END;
    case (s)
      5'd0:  st = mac_op(A_COS_A, B_WX, M_TMP, 1'b0, CAP_NONE);
      5'd1:  st = mac_op(A_COS_P, B_TMP, M_LOAD, 1'b0, CAP_NONE);
      5'd2:  st = mac_op(A_SIN_A, B_WY, M_TMP, 1'b0, CAP_NONE);
      5'd3:  st = mac_op(A_COS_P, B_TMP, M_ADD, 1'b1, CAP_NONE);
      5'd4:  st = mac_op(A_SIN_P, B_WZ, M_ADD_SH, 1'b0, CAP_CAM0);
      5'd5:  st = mac_op(A_SIN_A, B_WX, M_LOAD, 1'b0, CAP_NONE);
      5'd6:  st = mac_op(A_COS_A, B_WY, M_ADD, 1'b0, CAP_CAM1);
      5'd7:  st = mac_op(A_COS_A, B_WX, M_TMP, 1'b0, CAP_NONE);
      5'd8:  st = mac_op(A_SIN_P, B_TMP, M_LOAD, 1'b1, CAP_NONE);
      5'd9:  st = mac_op(A_SIN_A, B_WY, M_TMP, 1'b0, CAP_NONE);
      5'd10: st = mac_op(A_SIN_P, B_TMP, M_ADD, 1'b0, CAP_NONE);
      5'd11: st = mac_op(A_COS_P, B_WZ, M_ADD_SH, 1'b0, CAP_NONE);
      5'd12: st = mac_op(A_TRIG_ONE, B_OFF, M_FLOOR_ADD, 1'b0, CAP_DEPTH);
      5'd13: st = mac_op(A_FOCAL, B_CAM1, M_LOAD, 1'b0, CAP_NONE);
      5'd14: st = mac_op(A_COL_C, B_DEPTH, M_ADD, 1'b0, CAP_NONE);
      5'd15: st = div_op(D_COL);
      5'd16: st = mac_op(A_FOCAL, B_CAM0, M_LOAD, 1'b0, CAP_NONE);
      5'd17: st = mac_op(A_ROW_C, B_DEPTH, M_ADD, 1'b0, CAP_NONE);
      5'd18: st = div_op(D_ROW);
      5'd19: st = mac_op(A_LEVEL, B_ABS_X, M_LOAD, 1'b0, CAP_NONE);
      5'd20: st = div_op(D_BLUE);
      5'd21: st = mac_op(A_LEVEL, B_Z_DIFF, M_LOAD, 1'b0, CAP_NONE);
      5'd22: st = div_op(D_GREEN);
      default: st.kind = K_END;
    endcase
    return st;
  endfunction

  // Magnitude of a signed coordinate; the most negative value fits unsigned.
  function automatic logic [COORD_BITS-1:0] abs_coord(input logic [COORD_BITS-1:0] v);
    logic signed [COORD_BITS:0] e;
    e = {v[COORD_BITS-1], v};
    if (e < 0) e = -e;
    return e[COORD_BITS-1:0];
  endfunction

endpackage

// File: sv/ppc_mac.sv
// Shared multiply-accumulate unit: one registered product, then an accumulate step.
// Depends on ppc_pkg for widths and control types.
module ppc_mac
  import ppc_pkg::*;
(
  input  logic                    clk,
  input  mac_ctrl_t               ctrl,
  input  logic signed [OPA_W-1:0] op_a,
  input  logic signed [MB_W-1:0]  op_b,
  output logic signed [NUM_W-1:0] acc_r,
  output logic signed [NUM_W-1:0] acc_nxt,
  output logic signed [MB_W-1:0]  tmp_r
);

  logic signed [NUM_W-1:0] prod_r;
  logic signed [NUM_W-1:0] prod_nxt;
  logic signed [NUM_W-1:0] term;
  logic signed [MB_W-1:0]  tmp_nxt;

  assign prod_nxt = op_a * op_b;

  // Accumulate step selected by the sequencer.
  always_comb begin
    term    = ctrl.neg ? -prod_r : prod_r;
    acc_nxt = acc_r;
    tmp_nxt = tmp_r;
    case (ctrl.mode)
      M_TMP:       tmp_nxt = prod_r[MB_W-1:0];
      M_LOAD:      acc_nxt = term;
      M_ADD:       acc_nxt = acc_r + term;
      M_ADD_SH:    acc_nxt = acc_r + (term <<< TRIG_FRAC);
      M_FLOOR_ADD: acc_nxt = (acc_r >>> TRIG_FRAC) + term;
      default:     acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.acc_en) begin
      acc_r <= acc_nxt;
      tmp_r <= tmp_nxt;
    end
  end

endmodule

// File: sv/ppc_div.sv
// Restoring divider giving a short quotient, one bit per cycle.
// The top quotient bit flags a quotient of at least 2**PIX_BITS. Depends on ppc_pkg.
module ppc_div
  import ppc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [NUM_W-1:0] divisor,
  output logic             done_r,
  output logic [QUO_W-1:0] quo_r
);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] den_sh_r;
  logic             fits;

  assign fits = rem_r >= den_sh_r;

  // Control: count quotient bits and pulse done after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: compare and subtract the shifted divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r    <= dividend;
      den_sh_r <= divisor << (QUO_W - 1);
      quo_r    <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - den_sh_r;
      end
      quo_r    <= {quo_r[QUO_W-2:0], fits};
      den_sh_r <= den_sh_r >> 1;
    end
  end

endmodule

// File: sv/point_projection_colorizer_top.sv
// Sequence: a measure item gives no result; a project item raises out_tvalid after
// 19 multiply-accumulate steps (fetch, then accumulate), four divides (a start, then
// the divider's bit steps), one end step and one output load.
// No item is taken until a project item's result is loaded; a stalled result holds it longer.
// Reset (synchronous, rst_n low) restores the control and configuration registers and clears the extents.
// Depends on ppc_pkg, ppc_mac and ppc_div.
module point_projection_colorizer_top
  import ppc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // x_mm, y_mm, z_mm
  input  logic [IN_USER_W-1:0]  in_tuser,   // command, first_point
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pixel_column, pixel_row, red, green, blue
  output logic [0:0]            out_tuser,  // on_image
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  step_t             st;

  // Configuration registers.
  logic [SIZE_BITS-1:0]        height_r, width_r;
  logic signed [OFF_BITS-1:0]  off_r;
  logic signed [TRIG_BITS-1:0] cos_p_r, sin_p_r, cos_a_r, sin_a_r;

  // Extents.
  logic [COORD_BITS-1:0]        lax_r;
  logic signed [COORD_BITS-1:0] lz_r, gz_r;

  // Item being projected and intermediate values.
  logic signed [COORD_BITS-1:0] x_r, y_r, z_r;
  logic signed [CAM_W-1:0]      cam0_r, cam1_r;
  logic signed [DEPTH_W-1:0]    depth_r;
  logic [PIX_BITS-1:0]          col_val_r, row_val_r;
  logic                         col_ok_r, row_ok_r;
  logic [LEVEL_BITS-1:0]        blue_r, green_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_on_r;

  logic in_acc, out_free, cfg_acc;
  logic signed [COORD_BITS-1:0] in_x, in_z;
  logic [COORD_BITS-1:0]        in_ax, ax;
  logic signed [COORD_BITS:0]   wx, wy, wz, z_range, z_diff;
  logic range_pos, z_above, depth_pos, on_img;

  logic signed [OPA_W-1:0] op_a;
  logic signed [MB_W-1:0]  op_b;
  logic signed [NUM_W-1:0] acc_r, acc_nxt;
  logic signed [MB_W-1:0]  tmp_r;
  mac_ctrl_t               mac_ctrl;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_den;
  logic [QUO_W-1:0] div_quo;
  logic [LEVEL_BITS-1:0] level;
  logic signed [TRIG_BITS:0] cfg_trig;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_tready;

  assign in_x  = in_tdata[COORD_BITS-1:0];
  assign in_z  = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign in_ax = abs_coord(in_x);
  assign ax    = abs_coord(x_r);

  // Camera frame inputs: x and y negated.
  assign wx = -{x_r[COORD_BITS-1], x_r};
  assign wy = -{y_r[COORD_BITS-1], y_r};
  assign wz = {z_r[COORD_BITS-1], z_r};

  assign z_range   = {gz_r[COORD_BITS-1], gz_r} - {lz_r[COORD_BITS-1], lz_r};
  assign z_diff    = wz - {lz_r[COORD_BITS-1], lz_r};
  assign range_pos = !z_range[COORD_BITS] && (z_range != '0);
  assign z_above   = !z_diff[COORD_BITS] && (z_diff != '0);
  assign depth_pos = !depth_r[DEPTH_W-1] && (depth_r != '0);

  assign st = prog_step(step_r);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (st.a)
      A_COS_P:    op_a = OPA_W'(cos_p_r);
      A_SIN_P:    op_a = OPA_W'(sin_p_r);
      A_COS_A:    op_a = OPA_W'(cos_a_r);
      A_SIN_A:    op_a = OPA_W'(sin_a_r);
      A_TRIG_ONE: op_a = OPA_W'(TRIG_ONE);
      A_FOCAL:    op_a = OPA_W'(FOCAL_LENGTH);
      A_COL_C:    op_a = OPA_W'(width_r >> 1);
      A_ROW_C:    op_a = OPA_W'(height_r >> 1);
      A_LEVEL:    op_a = OPA_W'(LEVEL_MAX);
      default:    op_a = '0;
    endcase
    case (st.b)
      B_WX:     op_b = MB_W'(wx);
      B_WY:     op_b = MB_W'(wy);
      B_WZ:     op_b = MB_W'(wz);
      B_TMP:    op_b = tmp_r;
      B_OFF:    op_b = MB_W'(off_r);
      B_CAM0:   op_b = MB_W'(cam0_r);
      B_CAM1:   op_b = MB_W'(cam1_r);
      B_DEPTH:  op_b = depth_r;
      B_ABS_X:  op_b = MB_W'(ax);
      B_Z_DIFF: op_b = MB_W'(z_diff);
      default:  op_b = '0;
    endcase
  end

  // Divider operands: magnitude of the accumulator over the chosen divisor.
  always_comb begin
    div_num = acc_r[NUM_W-1] ? NUM_W'(-acc_r) : NUM_W'(acc_r);
    case (st.dest)
      D_COL, D_ROW: div_den = NUM_W'($unsigned(depth_r));
      D_BLUE:       div_den = NUM_W'(lax_r);
      D_GREEN:      div_den = NUM_W'($unsigned(z_range));
      default:      div_den = '0;
    endcase
    level = (div_quo > QUO_W'(LEVEL_MAX)) ? LEVEL_BITS'(LEVEL_MAX) : div_quo[LEVEL_BITS-1:0];
  end

  ppc_mac u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .op_a    (op_a),
    .op_b    (op_b),
    .acc_r   (acc_r),
    .acc_nxt (acc_nxt),
    .tmp_r   (tmp_r)
  );

  ppc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done_r   (div_done),
    .quo_r    (div_quo)
  );

  // Sequencer: next state and unit controls.
  always_comb begin
    state_nxt       = state_r;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_en = 1'b0;
    mac_ctrl.mode   = st.mode;
    mac_ctrl.neg    = st.neg;
    div_start       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser[0] == CMD_PROJECT) state_nxt = S_FETCH;
      end
      S_FETCH: begin
        case (st.kind)
          K_MAC: begin
            mac_ctrl.mul_en = 1'b1;
            state_nxt       = S_ACC;
          end
          K_DIV: begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        state_nxt       = S_FETCH;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_FETCH;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (in_acc) begin
      step_r <= '0;
    end else if ((state_r == S_ACC) || (state_r == S_DIV && div_done)) begin
      step_r <= step_r + 1'b1;
    end
  end

  // Configuration writes, held to their legal ranges.
  always_comb begin
    cfg_trig = (TRIG_BITS + 1)'($signed(cfg_data[TRIG_BITS-1:0]));
    if (cfg_trig > (TRIG_BITS + 1)'(TRIG_ONE)) cfg_trig = (TRIG_BITS + 1)'(TRIG_ONE);
    if (cfg_trig < -(TRIG_BITS + 1)'(TRIG_ONE)) cfg_trig = -(TRIG_BITS + 1)'(TRIG_ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= SIZE_BITS'(HEIGHT_RST);
      width_r  <= SIZE_BITS'(WIDTH_RST);
      off_r    <= OFF_BITS'(OFF_RST);
      cos_p_r  <= TRIG_BITS'(TRIG_ONE);
      sin_p_r  <= '0;
      cos_a_r  <= TRIG_BITS'(TRIG_ONE);
      sin_a_r  <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_HEIGHT: begin
          if (cfg_data[SIZE_BITS-1:0] == '0) height_r <= SIZE_BITS'(1);
          else if (cfg_data[SIZE_BITS-1:0] > SIZE_BITS'(SIZE_MAX))
            height_r <= SIZE_BITS'(SIZE_MAX);
          else height_r <= cfg_data[SIZE_BITS-1:0];
        end
        REG_WIDTH: begin
          if (cfg_data[SIZE_BITS-1:0] == '0) width_r <= SIZE_BITS'(1);
          else if (cfg_data[SIZE_BITS-1:0] > SIZE_BITS'(SIZE_MAX))
            width_r <= SIZE_BITS'(SIZE_MAX);
          else width_r <= cfg_data[SIZE_BITS-1:0];
        end
        REG_OFFSET: off_r   <= cfg_data[OFF_BITS-1:0];
        REG_COS_P:  cos_p_r <= cfg_trig[TRIG_BITS-1:0];
        REG_SIN_P:  sin_p_r <= cfg_trig[TRIG_BITS-1:0];
        REG_COS_A:  cos_a_r <= cfg_trig[TRIG_BITS-1:0];
        REG_SIN_A:  sin_a_r <= cfg_trig[TRIG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Extents, updated by measure items; first_point restarts them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lax_r <= '0;
      lz_r  <= {1'b0, {(COORD_BITS-1){1'b1}}};
      gz_r  <= {1'b1, {(COORD_BITS-1){1'b0}}};
    end else if (in_acc && in_tuser[0] == CMD_MEASURE) begin
      if (in_tuser[1]) begin
        lax_r <= in_ax;
        lz_r  <= in_z;
        gz_r  <= in_z;
      end else begin
        if (in_ax > lax_r) lax_r <= in_ax;
        if (in_z < lz_r) lz_r <= in_z;
        if (in_z > gz_r) gz_r <= in_z;
      end
    end
  end

  // Item coordinates and captured intermediate values.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_x;
      y_r <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      z_r <= in_z;
    end
    if (state_r == S_ACC) begin
      case (st.cap)
        CAP_CAM0:  cam0_r  <= CAM_W'(acc_nxt >>> TRIG_FRAC);
        CAP_CAM1:  cam1_r  <= CAM_W'(acc_nxt);
        CAP_DEPTH: depth_r <= DEPTH_W'(acc_nxt);
        default: ;
      endcase
    end
    if (state_r == S_DIV && div_done) begin
      case (st.dest)
        D_COL: begin
          col_val_r <= div_quo[PIX_BITS-1:0];
          col_ok_r  <= acc_r[NUM_W-1] ? (div_quo == '0) : (div_quo < width_r);
        end
        D_ROW: begin
          row_val_r <= div_quo[PIX_BITS-1:0];
          row_ok_r  <= acc_r[NUM_W-1] ? (div_quo == '0) : (div_quo < height_r);
        end
        D_BLUE:  blue_r  <= (lax_r == '0) ? '0 : level;
        D_GREEN: green_r <= (range_pos && z_above) ? level : '0;
        default: ;
      endcase
    end
  end

  // Output register.
  assign on_img = depth_pos && col_ok_r && row_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_on_r   <= on_img;
      out_data_r <= {blue_r, green_r, ~blue_r,
                     on_img ? row_val_r : '0, on_img ? col_val_r : '0};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_on_r;

endmodule

// File: sv/ppc_checker.sv
// Port-level checks of the point projection colorizer, bound to its top level.
// Depends on ppc_pkg and point_projection_colorizer_top.
module ppc_checker
  import ppc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]            out_tuser,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A project item keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == CMD_PROJECT |=> !in_tready)
    else $error("project item did not occupy the block");

  // Off-image points report pixel zero.
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[2*PIX_BITS-1:0] == '0)
    else $error("off-image point with nonzero pixel");

  // Red and blue always sum to full level.
  a_red_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2*PIX_BITS+LEVEL_BITS-1:2*PIX_BITS] ==
                   ~out_tdata[OUT_DATA_W-1:OUT_DATA_W-LEVEL_BITS])
    else $error("red is not the complement of blue");

endmodule

bind point_projection_colorizer_top ppc_checker u_ppc_checker (.*);
